>>> hdl/assert_macros.svh
// Assertion macros used by the block's top-level RTL file.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds on every clock edge outside reset.
`define MFPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is always followed by a consequence in the next cycle.
`define MFPS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mfps_pkg.sv
// Shared types, sizes and helper functions of the falling path sum block.
// Used by the top level and the testbench; depends on nothing.
package mfps_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 1024;
  localparam int CELL_WIDTH = 16;
  localparam int SUM_WIDTH  = 26;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int NC_W       = COL_W + 1;
  localparam int NR_W       = ROW_W + 1;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = NR_W;

  typedef logic signed [SUM_WIDTH-1:0]  sum_t;
  typedef logic signed [CELL_WIDTH-1:0] cell_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;

  localparam cfg_idx_t CFG_NUM_ROWS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_NUM_COLS = cfg_idx_t'(1);

  localparam sum_t SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam sum_t SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};

  function automatic sum_t sat_sum(input logic signed [SUM_WIDTH:0] v);
    logic signed [SUM_WIDTH:0] hi;
    logic signed [SUM_WIDTH:0] lo;
    hi = {SUM_MAX[SUM_WIDTH-1], SUM_MAX};
    lo = {SUM_MIN[SUM_WIDTH-1], SUM_MIN};
    if (v > hi) begin
      return SUM_MAX;
    end else if (v < lo) begin
      return SUM_MIN;
    end
    return v[SUM_WIDTH-1:0];
  endfunction

endpackage

>>> hdl/mfps_row_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// A read of the entry written in the same cycle returns the new data. No dependencies.
module mfps_row_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 26
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/max_falling_path_sum_top.sv
// Maximum falling path sum over a matrix streamed in row-major order, one cell per word.
// The block takes one cell every clock cycle unless stalled and keeps the previous row's path
// sums in a row RAM that is read two columns ahead of the cell being taken and rewritten in
// place from the stage-two registers; a three-entry window and two row-start registers supply
// the neighbors. The result word is registered in an output register after a matrix's last
// cell; input stalls only while a finished result is still waiting and the next matrix's last
// cell reaches the result stage. Writing num_rows or num_cols restarts the problem.
// Depends on mfps_pkg, mfps_row_ram and assert_macros.svh.
`include "assert_macros.svh"

module max_falling_path_sum_top
  import mfps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] cell_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [25:0] best_sum, [31:26] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NR_W-1:0]  nr_cfg_r;
  logic [NC_W-1:0]  nc_cfg_r;
  logic [NR_W-1:0]  nr_eff;
  logic [NC_W-1:0]  nc_eff;
  logic             cfg_we;
  logic             restart;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  sum_t             w_left_r;
  sum_t             w_mid_r;
  sum_t             w_right_r;
  logic             use_rd_r;
  sum_t             first0_r;
  sum_t             first1_r;

  logic             in_acc;
  cell_t            cell_val;
  sum_t             rd_data;
  sum_t             right_eff;
  logic             has_left;
  logic             has_right;
  sum_t             best;
  sum_t             cell_sum;
  logic             last_col;
  logic             last_row;
  logic [NC_W-1:0]  col_p1;
  logic [NC_W-1:0]  col_p2;
  logic             rd_en;
  sum_t             fwd0;
  sum_t             fwd1;

  logic             s2_valid_r;
  sum_t             s2_sum_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_last_row_r;
  logic             s2_end_r;
  logic             stall;
  logic             s2_adv;
  sum_t             run_best_r;
  sum_t             best_cand;
  logic             out_valid_r;
  sum_t             out_sum_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && ((cfg_index == CFG_NUM_ROWS) || (cfg_index == CFG_NUM_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nr_cfg_r <= NR_W'(1);
      nc_cfg_r <= NC_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: nr_cfg_r <= cfg_data[NR_W-1:0];
        CFG_NUM_COLS: nc_cfg_r <= cfg_data[NC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nr_cfg_r == '0) begin
      nr_eff = NR_W'(1);
    end else if (nr_cfg_r > NR_W'(MAX_ROWS)) begin
      nr_eff = NR_W'(MAX_ROWS);
    end else begin
      nr_eff = nr_cfg_r;
    end
    if (nc_cfg_r == '0) begin
      nc_eff = NC_W'(1);
    end else if (nc_cfg_r > NC_W'(MAX_COLS)) begin
      nc_eff = NC_W'(MAX_COLS);
    end else begin
      nc_eff = nc_cfg_r;
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign cell_val  = in_tdata[CELL_WIDTH-1:0];
  assign right_eff = use_rd_r ? rd_data : w_right_r;
  assign col_p1    = {1'b0, col_r} + NC_W'(1);
  assign col_p2    = {1'b0, col_r} + NC_W'(2);
  assign has_left  = (col_r != '0);
  assign has_right = (col_p1 < nc_eff);
  assign last_col  = (col_p1 == nc_eff);
  assign last_row  = (({1'b0, row_r} + NR_W'(1)) == nr_eff);
  assign rd_en     = in_acc && !last_col && (col_p2 < nc_eff);

  always_comb begin
    best = w_mid_r;
    if (has_left && (w_left_r > best)) begin
      best = w_left_r;
    end
    if (has_right && (right_eff > best)) begin
      best = right_eff;
    end
    if (row_r == '0) begin
      cell_sum = SUM_WIDTH'(cell_val);
    end else begin
      cell_sum = sat_sum((SUM_WIDTH+1)'(cell_val) + (SUM_WIDTH+1)'(best));
    end
    fwd0 = (col_r == COL_W'(0)) ? cell_sum : first0_r;
    fwd1 = (col_r == COL_W'(1)) ? cell_sum : first1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      use_rd_r <= 1'b0;
    end else if (restart) begin
      row_r    <= '0;
      col_r    <= '0;
      use_rd_r <= 1'b0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r    <= '0;
        row_r    <= last_row ? '0 : row_r + ROW_W'(1);
        use_rd_r <= 1'b0;
      end else begin
        col_r    <= col_r + COL_W'(1);
        use_rd_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (last_col) begin
        w_mid_r   <= fwd0;
        w_right_r <= fwd1;
      end else begin
        w_left_r <= w_mid_r;
        w_mid_r  <= right_eff;
      end
      if (col_r == COL_W'(0)) begin
        first0_r <= cell_sum;
      end
      if (col_r == COL_W'(1)) begin
        first1_r <= cell_sum;
      end
    end
  end

  mfps_row_ram #(
    .DEPTH(MAX_COLS),
    .WIDTH(SUM_WIDTH)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (s2_valid_r),
    .wr_addr(s2_col_r),
    .wr_data(s2_sum_r),
    .rd_en  (rd_en),
    .rd_addr(col_p2[COL_W-1:0]),
    .rd_data(rd_data)
  );

  assign stall     = s2_valid_r && s2_end_r && out_valid_r && !out_tready;
  assign in_tready = !stall;
  assign s2_adv    = s2_valid_r && !stall;
  assign best_cand = (s2_sum_r > run_best_r) ? s2_sum_r : run_best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (!stall) begin
      s2_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_sum_r      <= cell_sum;
      s2_col_r      <= col_r;
      s2_last_row_r <= last_row;
      s2_end_r      <= last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_best_r  <= SUM_MIN;
      out_valid_r <= 1'b0;
    end else begin
      if (restart) begin
        run_best_r <= SUM_MIN;
      end else if (s2_adv && s2_last_row_r) begin
        if (s2_end_r) begin
          run_best_r <= SUM_MIN;
        end else begin
          run_best_r <= best_cand;
        end
      end
      if (!restart && s2_adv && s2_end_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_end_r) begin
      out_sum_r <= best_cand;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32-SUM_WIDTH){1'b0}}, out_sum_r};

  `MFPS_ASSERT(a_stall_needs_result, in_tready || out_valid_r, "input stalled with no result pending")
  `MFPS_ASSERT(a_col_in_row, ({1'b0, col_r} < nc_eff), "column index beyond row length")
  `MFPS_ASSERT(a_row_in_matrix, ({1'b0, row_r} < nr_eff), "row index beyond matrix height")
  `MFPS_ASSERT_NEXT(a_end_gives_result, s2_adv && s2_end_r, out_valid_r, "final cell gave no result")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for max_falling_path_sum_top: streams matrices of signed cells
// and checks every best path sum against an in-bench row-by-row predictor.
// Depends on mfps_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import mfps_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_CELLS = 300;
  localparam int unsigned QUIET_CELLS  = 100;
  localparam cell_t CELL_MAX = {1'b0, {(CELL_WIDTH-1){1'b1}}};
  localparam cell_t CELL_MIN = {1'b1, {(CELL_WIDTH-1){1'b0}}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // [15:0] cell_value
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [31:0]           out_tdata;       // [25:0] best_sum, [31:26] zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_NUM_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  max_falling_path_sum_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state: register copies and the two rows of path sums.
  logic [NR_W-1:0] rows_reg;
  logic [NC_W-1:0] cols_reg;
  sum_t            upper_sums [MAX_COLS];
  sum_t            row_sums [MAX_COLS];
  int unsigned     row_pos;
  int unsigned     col_pos;
  sum_t            path_best;

  sum_t        pending_best_sums [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned cells_sent = 0;
  int unsigned sums_checked = 0;
  int unsigned reg_writes = 0;
  bit          idle_on = 1'b1;

  function automatic int unsigned eff_count(input int unsigned raw, input int unsigned cap);
    if (raw == 0) begin
      return 1;
    end
    return (raw > cap) ? cap : raw;
  endfunction

  function automatic void restart_problem();
    row_pos = 0;
    col_pos = 0;
    path_best = SUM_MIN;
  endfunction

  function automatic void reset_predictor();
    rows_reg = 1;
    cols_reg = 1;
    foreach (upper_sums[i]) begin
      upper_sums[i] = '0;
      row_sums[i] = '0;
    end
    restart_problem();
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_NUM_ROWS) begin
      rows_reg = value[NR_W-1:0];
      restart_problem();
    end else if (idx == CFG_NUM_COLS) begin
      cols_reg = value[NC_W-1:0];
      restart_problem();
    end
  endfunction

  // Folds one cell into the current row; returns 1 with the best sum when the matrix ends.
  function automatic bit fold_cell(input cell_t cell_val, output sum_t best_out);
    int unsigned nr;
    int unsigned nc;
    int unsigned c;
    longint      total;
    sum_t        up_best;
    sum_t        s;
    nr = eff_count(rows_reg, MAX_ROWS);
    nc = eff_count(cols_reg, MAX_COLS);
    c = (col_pos >= nc) ? nc - 1 : col_pos;
    if (row_pos == 0) begin
      total = cell_val;
    end else begin
      up_best = upper_sums[c];
      if (c > 0 && upper_sums[c-1] > up_best) begin
        up_best = upper_sums[c-1];
      end
      if (c + 1 < nc && upper_sums[c+1] > up_best) begin
        up_best = upper_sums[c+1];
      end
      total = longint'(cell_val) + longint'(up_best);
    end
    if (total > SUM_MAX) begin
      s = SUM_MAX;
    end else if (total < SUM_MIN) begin
      s = SUM_MIN;
    end else begin
      s = sum_t'(total);
    end
    row_sums[c] = s;
    if (row_pos + 1 >= nr && s > path_best) begin
      path_best = s;
    end
    best_out = path_best;
    c++;
    if (c < nc) begin
      col_pos = c;
      return 1'b0;
    end
    if (row_pos + 1 >= nr) begin
      restart_problem();
      return 1'b1;
    end
    upper_sums = row_sums;
    row_pos++;
    col_pos = 0;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_best_sums.size() == 0) begin
        $error("best_sum: no result expected, got %0d", $signed(out_tdata[SUM_WIDTH-1:0]));
        errors++;
      end else begin
        if (out_tdata[SUM_WIDTH-1:0] !== pending_best_sums[0]) begin
          $error("best_sum: expected %0d, got %0d", pending_best_sums[0],
                 $signed(out_tdata[SUM_WIDTH-1:0]));
          errors++;
        end
        void'(pending_best_sums.pop_front());
        sums_checked++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_cell(input cell_t cell_val);
    sum_t best;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= cell_val;
    do @(posedge clk); while (!in_tready);
    cells_sent++;
    if (fold_cell(cell_val, best)) begin
      pending_best_sums.push_back(best);
    end
  endtask

  task automatic stop_cells();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_best_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value,
                           input bit last_write);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (last_write) begin
      cfg_valid <= 1'b0;
    end
    apply_reg(idx, value);
    reg_writes++;
  endtask

  task automatic set_sizes(input int unsigned rows_word, input int unsigned cols_word);
    stop_cells();
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_NUM_ROWS, rows_word[CFG_DATA_W-1:0], 1'b0);
      write_reg(CFG_NUM_COLS, cols_word[CFG_DATA_W-1:0], 1'b1);
    end else begin
      write_reg(CFG_NUM_COLS, cols_word[CFG_DATA_W-1:0], 1'b0);
      write_reg(CFG_NUM_ROWS, rows_word[CFG_DATA_W-1:0], 1'b1);
    end
  endtask

  function automatic cell_t random_cell();
    case ($urandom_range(0, 11))
      0: return CELL_MAX;
      1: return CELL_MIN;
      2: return '0;
      3: return '1;
      default: return cell_t'($urandom);
    endcase
  endfunction

  task automatic send_matrix_of(input cell_t cell_val);
    int unsigned total;
    total = eff_count(rows_reg, MAX_ROWS) * eff_count(cols_reg, MAX_COLS);
    repeat (total) send_cell(cell_val);
  endtask

  task automatic test_single_cells();
    send_cell(CELL_MAX);
    send_cell(CELL_MIN);
    send_cell('0);
    send_cell('1);
  endtask

  task automatic test_small_matrix();
    cell_t cells [9];
    cells = '{16'sd5, -16'sd3, 16'sd7, -16'sd2, 16'sd4, CELL_MIN, CELL_MAX, -16'sd1, 16'sd0};
    set_sizes(3, 3);
    foreach (cells[i]) begin
      send_cell(cells[i]);
    end
  endtask

  task automatic test_zero_sizes();
    set_sizes(0, 0);
    send_cell(cell_t'($urandom));
    send_cell(cell_t'($urandom));
  endtask

  task automatic test_restart();
    cfg_idx_t spare;
    set_sizes(2, 3);
    send_cell(16'sd100);
    send_cell(-16'sd50);
    stop_cells();
    wait_idle();
    spare = cfg_idx_t'($urandom_range(int'(CFG_NUM_COLS) + 1, (1 << CFG_IDX_W) - 1));
    write_reg(spare, CFG_DATA_W'($urandom), 1'b1);
    send_cell(16'sd7);
    send_cell(16'sd8);
    set_sizes(2, 3);
    repeat (6) send_cell(random_cell());
  endtask

  task automatic test_max_sizes();
    set_sizes((1 << NR_W) - 1, 1);
    send_matrix_of(CELL_MIN);
    set_sizes(2, (1 << NC_W) - 1);
    repeat (2 * MAX_COLS) send_cell(random_cell());
  endtask

  task automatic test_random_problems();
    int unsigned first_cell;
    int unsigned problem;
    int unsigned rows_word;
    int unsigned cols_word;
    int unsigned total;
    int unsigned cut;
    first_cell = cells_sent;
    problem = 0;
    while (cells_sent - first_cell < RANDOM_CELLS) begin
      if (cells_sent - first_cell >= RANDOM_CELLS - QUIET_CELLS) begin
        idle_on = 1'b0;
      end
      if (problem == 0 || $urandom_range(0, 3) == 0) begin
        rows_word = $urandom_range(1, 6);
        cols_word = $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) begin
          rows_word = $urandom_range(7, 24);
        end
        if ($urandom_range(0, 9) == 0) begin
          cols_word = $urandom_range(11, MAX_COLS);
          rows_word = $urandom_range(1, 2);
        end
        if ($urandom_range(0, 19) == 0) begin
          rows_word = 0;
        end
        if ($urandom_range(0, 19) == 0) begin
          cols_word = 0;
        end
        if ($urandom_range(0, 7) == 0) begin
          cols_word = cols_word | ($urandom_range(0, 3) << NC_W);
        end
        set_sizes(rows_word, cols_word);
      end
      total = eff_count(rows_reg, MAX_ROWS) * eff_count(cols_reg, MAX_COLS);
      cut = total;
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(0, total - 1);
      end
      repeat (cut) send_cell(random_cell());
      if (cut != total) begin
        set_sizes(rows_reg, cols_reg);
      end else if (problem == 2 || $urandom_range(0, 24) == 0) begin
        stop_cells();
        wait_idle();
      end
      problem++;
    end
  endtask

  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_cells();
    test_small_matrix();
    test_zero_sizes();
    test_restart();
    test_max_sizes();
    test_random_problems();
    stop_cells();
    wait_idle();
    $display("Streamed %0d cells and checked %0d path sums after %0d register writes,",
             cells_sent, sums_checked, reg_writes);
    $display("covering cell extremes, zero and oversized sizes, restarts and full-size rows.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
